@@ hdl/assert_macros.svh @@
// Assertion helpers used by radio_frame_crc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk while rst_n is high.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/rfcc_pkg.sv @@
package rfcc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned MAXSZ_W  = 9;

    localparam logic [CRC_W-1:0]   CRC_POLY      = 16'h1021;
    localparam logic [BYTE_W-1:0]  MIN_LENGTH    = 8'd10;
    localparam logic [BYTE_W-1:0]  CRC_FIRST_POS = 8'd5;
    localparam logic [MAXSZ_W-1:0] MAX_SIZE_RST  = 9'd256;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LEN_ERR = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   frame_length;
        logic [CRC_W-1:0]    computed_crc;
        logic [CRC_W-1:0]    received_crc;
    } result_t;

    // CRC-16, MSB first, one whole byte per call.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] rem;
        rem = crc_in ^ {data, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (rem[CRC_W-1])
                rem = {rem[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                rem = {rem[CRC_W-2:0], 1'b0};
        end
        return rem;
    endfunction

endpackage

@@ hdl/radio_frame_crc_checker.sv @@
// Frame checker for received radio frames, one byte per transfer. A transfer with
// frame_start high carries the length byte L; the frame is L+1 bytes long. A length
// below 10 or not below max_frame_size gives a header-length result right away.
// Otherwise a CRC-16 (0x1021, seed 0, MSB first) runs over bytes 5 to L-2, byte
// L-2 must be zero, and the last byte yields one result: OK or CRC error, with the
// computed CRC and the CRC received in bytes L-1 (high) and L (low). The block takes
// one byte per cycle unless a result still waiting on out_ready holds it up; a byte
// passes the input register, then the byte-wide CRC update and the result register
// that holds its result. max_frame_size may only change while the block is idle.
`include "assert_macros.svh"

module radio_frame_crc_checker
    import rfcc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                max_frame_size_we,
    input  logic [MAXSZ_W-1:0]  max_frame_size,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                frame_start,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [BYTE_W-1:0]   frame_length,
    output logic [CRC_W-1:0]    computed_crc,
    output logic [CRC_W-1:0]    received_crc
);

    logic [MAXSZ_W-1:0] max_size_reg;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_start_reg;

    logic              in_frame_reg,  in_frame_next;
    logic [BYTE_W-1:0] byte_pos_reg,  byte_pos_next;
    logic [BYTE_W-1:0] length_reg,    length_next;
    logic [CRC_W-1:0]  crc_run_reg,   crc_run_next;
    logic [BYTE_W-1:0] crc_hi_reg,    crc_hi_next;
    logic              marker_ok_reg, marker_ok_next;

    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    has_result;
    logic    s1_go;
    logic    len_bad;
    logic [BYTE_W-1:0] last_data_pos;
    logic [CRC_W-1:0]  rx_crc;

    assign len_bad       = (s1_byte_reg < MIN_LENGTH) ||
                           ({1'b0, s1_byte_reg} >= max_size_reg);
    assign last_data_pos = length_reg - 8'd2;
    assign rx_crc        = {crc_hi_reg, s1_byte_reg};

    always_comb
    begin
        has_result     = 1'b0;
        result_next    = '0;
        in_frame_next  = in_frame_reg;
        byte_pos_next  = byte_pos_reg;
        length_next    = length_reg;
        crc_run_next   = crc_run_reg;
        crc_hi_next    = crc_hi_reg;
        marker_ok_next = marker_ok_reg;

        if (s1_start_reg)
        begin
            if (len_bad)
            begin
                // A bad length closes any open frame and reports at once.
                in_frame_next            = 1'b0;
                has_result               = 1'b1;
                result_next.status       = STATUS_LEN_ERR;
                result_next.frame_length = s1_byte_reg;
            end
            else
            begin
                in_frame_next  = 1'b1;
                length_next    = s1_byte_reg;
                byte_pos_next  = 8'd1;
                crc_run_next   = '0;
                crc_hi_next    = '0;
                marker_ok_next = 1'b0;
            end
        end
        else if (in_frame_reg)
        begin
            byte_pos_next = byte_pos_reg + 8'd1;
            if (byte_pos_reg >= CRC_FIRST_POS && byte_pos_reg <= last_data_pos)
            begin
                crc_run_next = crc16_byte(crc_run_reg, s1_byte_reg);
                if (byte_pos_reg == last_data_pos)
                    marker_ok_next = (s1_byte_reg == '0);
            end
            else if (byte_pos_reg == length_reg - 8'd1)
            begin
                crc_hi_next = s1_byte_reg;
            end
            else if (byte_pos_reg == length_reg)
            begin
                has_result               = 1'b1;
                result_next.status       = (marker_ok_reg && rx_crc == crc_run_reg) ?
                                           STATUS_OK : STATUS_CRC_ERR;
                result_next.frame_length = length_reg;
                result_next.computed_crc = crc_run_reg;
                result_next.received_crc = rx_crc;
                in_frame_next            = 1'b0;
                byte_pos_next            = '0;
            end
        end
    end

    // The held byte moves on unless its result would land on a result still waiting.
    assign s1_go    = s1_valid_reg && (!has_result || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg  <= MAX_SIZE_RST;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_frame_reg  <= 1'b0;
            byte_pos_reg  <= '0;
            length_reg    <= '0;
            crc_run_reg   <= '0;
            crc_hi_reg    <= '0;
            marker_ok_reg <= 1'b0;
        end
        else
        begin
            if (max_frame_size_we)
                max_size_reg <= max_frame_size;

            if (in_ready)
                s1_valid_reg <= in_valid;

            if (s1_go)
            begin
                in_frame_reg  <= in_frame_next;
                byte_pos_reg  <= byte_pos_next;
                length_reg    <= length_next;
                crc_run_reg   <= crc_run_next;
                crc_hi_reg    <= crc_hi_next;
                marker_ok_reg <= marker_ok_next;
            end

            if (s1_go && has_result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg  <= data_byte;
            s1_start_reg <= frame_start;
        end
        if (s1_go && has_result)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign frame_length = result_reg.frame_length;
    assign computed_crc = result_reg.computed_crc;
    assign received_crc = result_reg.received_crc;

    `ASSERT_CLK(a_open_frame_length, in_frame_reg |-> (length_reg >= MIN_LENGTH),
                "open frame holds a length below the minimum")
    `ASSERT_CLK(a_position_in_frame,
                in_frame_reg |-> (byte_pos_reg != '0 && byte_pos_reg <= length_reg),
                "byte position outside the open frame")
    `ASSERT_CLK(a_len_err_fields,
                (out_valid_reg && result_reg.status == STATUS_LEN_ERR) |->
                (result_reg.computed_crc == '0 && result_reg.received_crc == '0),
                "header-length result carries nonzero CRC fields")
    `ASSERT_CLK(a_no_overwrite, (out_valid_reg && !out_ready) |=> $stable(result_reg),
                "waiting result was overwritten")

endmodule

@@ dv/tb_radio_frame_crc_checker.sv @@
`timescale 1ns / 1ps

module tb_radio_frame_crc_checker;
    import rfcc_pkg::*;

    localparam logic [7:0]  FRAME_MIN_LEN = 8'd10;
    localparam logic [7:0]  CRC_START_POS = 8'd5;
    localparam logic [15:0] CRC16_POLY    = 16'h1021;
    localparam int          LONG_HOLD     = 300;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          NUM_ROWS      = 27;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_CRC,
        FRAME_BAD_MARKER,
        FRAME_BAD_HEADER,
        FRAME_TRUNCATED,
        FRAME_NOISE
    } frame_kind_t;

    typedef struct packed {
        logic    start;
        logic [7:0] data;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                max_frame_size_we = 1'b0;
    logic [MAXSZ_W-1:0]  max_frame_size = 9'd256;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                frame_start = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   frame_length;
    logic [CRC_W-1:0]    computed_crc;
    logic [CRC_W-1:0]    received_crc;

    // Checker copy of the frame state and the size register.
    logic [8:0]  chk_max_size = 9'd256;
    logic        chk_in_frame = 1'b0;
    logic [7:0]  chk_pos = '0;
    logic [7:0]  chk_len = '0;
    logic [15:0] chk_crc = '0;
    logic [15:0] chk_crc_hi = '0;
    logic        chk_marker_ok = 1'b0;

    result_t     pending_results [$];
    stim_row_t   directed_rows [NUM_ROWS];
    int          mismatches = 0;
    int          sent_items = 0;
    int          tx_idle_pct = 10;
    int          rx_idle_pct = 10;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          rx_stall = 0;
    int          stall_cycles = 0;
    int          idle_choice [3] = '{0, 5, 20};
    int unsigned cfg_plan [7] = '{11, 0, 511, 10, 255, 256, 0};
    int          phase_size [7] = '{80, 25, 300, 20, 80, 60, 100};

    radio_frame_crc_checker u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .max_frame_size_we (max_frame_size_we),
        .max_frame_size    (max_frame_size),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_byte         (data_byte),
        .frame_start       (frame_start),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .frame_length      (frame_length),
        .computed_crc      (computed_crc),
        .received_crc      (received_crc)
    );

    always #10 clk = ~clk;

    // Bit-serial form of the byte-wide CRC update.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc_in;
        for (int k = 7; k >= 0; k--)
        begin
            fb  = acc[15] ^ b[k];
            acc = {acc[14:0], 1'b0};
            if (fb)
                acc = acc ^ CRC16_POLY;
        end
        return acc;
    endfunction

    function automatic bit predict_frame_byte(input logic st, input logic [7:0] b,
                                              output result_t r);
        logic [15:0] rx;
        r = '0;
        if (st)
        begin
            chk_in_frame = 1'b0;
            if (b < FRAME_MIN_LEN || {1'b0, b} >= chk_max_size)
            begin
                r.status       = STATUS_LEN_ERR;
                r.frame_length = b;
                return 1'b1;
            end
            chk_in_frame  = 1'b1;
            chk_len       = b;
            chk_pos       = 8'd1;
            chk_crc       = '0;
            chk_crc_hi    = '0;
            chk_marker_ok = 1'b0;
            return 1'b0;
        end
        if (!chk_in_frame)
            return 1'b0;
        if (chk_pos >= CRC_START_POS && chk_pos <= chk_len - 8'd2)
        begin
            chk_crc = crc16_update(chk_crc, b);
            if (chk_pos == chk_len - 8'd2)
                chk_marker_ok = (b == 8'h00);
        end
        else if (chk_pos == chk_len - 8'd1)
        begin
            chk_crc_hi = {b, 8'h00};
        end
        else if (chk_pos == chk_len)
        begin
            rx = chk_crc_hi | {8'h00, b};
            r.status       = (chk_marker_ok && rx == chk_crc) ? STATUS_OK : STATUS_CRC_ERR;
            r.frame_length = chk_len;
            r.computed_crc = chk_crc;
            r.received_crc = rx;
            chk_in_frame   = 1'b0;
            chk_pos        = '0;
            return 1'b1;
        end
        chk_pos = chk_pos + 8'd1;
        return 1'b0;
    endfunction

    // Offers one byte, waits for the transfer, then books the expected result.
    task automatic push_byte(input logic st, input logic [7:0] b,
                             input logic typed = 1'b0, input result_t typed_res = '0);
        result_t r;
        bit      has;
        if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        frame_start <= st;
        do @(posedge clk); while (!in_ready);
        has = predict_frame_byte(st, b, r);
        if (typed)
            pending_results.push_back(typed_res);
        else if (has)
            pending_results.push_back(r);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return FRAME_GOOD;
        if (r < 67) return FRAME_BAD_CRC;
        if (r < 75) return FRAME_BAD_MARKER;
        if (r < 87) return FRAME_BAD_HEADER;
        if (r < 95) return FRAME_TRUNCATED;
        return FRAME_NOISE;
    endfunction

    // Builds one frame for the current size setting. A nonzero forced_len fixes L.
    task automatic send_frame(input frame_kind_t kind, input int forced_len);
        logic [7:0]  bytes [$];
        logic [15:0] crc;
        frame_kind_t k;
        int          upper;
        int          len;
        int          cut;
        int          r;
        k     = kind;
        upper = (chk_max_size > 9'd255) ? 255 : int'(chk_max_size) - 1;
        if (upper < int'(FRAME_MIN_LEN) && k != FRAME_NOISE)
            k = FRAME_BAD_HEADER;
        case (k)
            FRAME_NOISE:
            begin
                cut = $urandom_range(1, 4);
                repeat (cut) push_byte(1'b0, 8'($urandom));
                sent_items += cut;
            end
            FRAME_BAD_HEADER:
            begin
                if (upper >= 255 || $urandom_range(0, 1) == 0)
                    len = $urandom_range(0, 9);
                else
                    len = $urandom_range(upper + 1, 255);
                push_byte(1'b1, 8'(len));
                sent_items++;
            end
            default:
            begin
                r = $urandom_range(0, 99);
                if (forced_len != 0)
                    len = forced_len;
                else if (r < 85)
                    len = $urandom_range(10, (upper < 24) ? upper : 24);
                else if (r < 97)
                    len = $urandom_range(10, (upper < 60) ? upper : 60);
                else
                    len = $urandom_range(10, upper);
                bytes.push_back(8'(len));
                for (int p = 1; p <= len; p++)
                    bytes.push_back(8'($urandom));
                bytes[len-2] = (k == FRAME_BAD_MARKER) ? 8'($urandom_range(1, 255)) : 8'h00;
                crc = '0;
                for (int p = CRC_START_POS; p <= len - 2; p++)
                    crc = crc16_update(crc, bytes[p]);
                if (k == FRAME_BAD_CRC)
                    crc = crc ^ 16'($urandom_range(1, 65535));
                bytes[len-1] = crc[15:8];
                bytes[len]   = crc[7:0];
                // A truncated frame stops short of its last byte.
                cut = (k == FRAME_TRUNCATED) ? $urandom_range(1, len) : len + 1;
                for (int p = 0; p < cut; p++)
                    push_byte(p == 0, bytes[p]);
                sent_items += cut;
            end
        endcase
    endtask

    function automatic void check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: status=%0d length=%0d crc=%h rx=%h",
                         status, frame_length, computed_crc, received_crc);
            return;
        end
        want = pending_results.pop_front();
        if (status !== want.status || frame_length !== want.frame_length ||
            computed_crc !== want.computed_crc || received_crc !== want.received_crc)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected status=%0d length=%0d crc=%h rx=%h,",
                         want.status, want.frame_length, want.computed_crc,
                         want.received_crc,
                         " got status=%0d length=%0d crc=%h rx=%h",
                         status, frame_length, computed_crc, received_crc);
        end
    endfunction

    // Result side: checks each transfer and stalls in random bursts or on request.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result();
        if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            rx_stall    <= LONG_HOLD;
            out_ready   <= 1'b0;
        end
        else if (rx_stall > 1)
        begin
            rx_stall  <= rx_stall - 1;
            out_ready <= 1'b0;
        end
        else if (rx_stall == 1)
        begin
            rx_stall  <= 0;
            out_ready <= 1'b1;
        end
        else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct)
        begin
            rx_stall  <= $urandom_range(1, 15);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int goal;
        // Header errors, a frame of zeros (CRC zero), a byte outside any frame,
        // and a long frame dropped by a new start that then fails its CRC.
        directed_rows = '{
            '{1'b1, 8'd9,   1'b1, '{STATUS_LEN_ERR, 8'd9, 16'h0000, 16'h0000}},
            '{1'b1, 8'd0,   1'b1, '{STATUS_LEN_ERR, 8'd0, 16'h0000, 16'h0000}},
            '{1'b0, 8'hFF,  1'b0, '0},
            '{1'b1, 8'd10,  1'b0, '0},
            '{1'b0, 8'h00,  1'b0, '0},
            '{1'b0, 8'h00,  1'b0, '0},
            '{1'b0, 8'h00,  1'b0, '0},
            '{1'b0, 8'h00,  1'b0, '0},
            '{1'b0, 8'h00,  1'b0, '0},
            '{1'b0, 8'h00,  1'b0, '0},
            '{1'b0, 8'h00,  1'b0, '0},
            '{1'b0, 8'h00,  1'b0, '0},
            '{1'b0, 8'h00,  1'b0, '0},
            '{1'b0, 8'h00,  1'b1, '{STATUS_OK, 8'd10, 16'h0000, 16'h0000}},
            '{1'b1, 8'd255, 1'b0, '0},
            '{1'b0, 8'hAA,  1'b0, '0},
            '{1'b1, 8'd10,  1'b0, '0},
            '{1'b0, 8'hFF,  1'b0, '0},
            '{1'b0, 8'hFF,  1'b0, '0},
            '{1'b0, 8'hFF,  1'b0, '0},
            '{1'b0, 8'hFF,  1'b0, '0},
            '{1'b0, 8'hFF,  1'b0, '0},
            '{1'b0, 8'hFF,  1'b0, '0},
            '{1'b0, 8'hFF,  1'b0, '0},
            '{1'b0, 8'hFF,  1'b0, '0},
            '{1'b0, 8'hFF,  1'b0, '0},
            '{1'b0, 8'hFF,  1'b0, '0}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            push_byte(directed_rows[i].start, directed_rows[i].data,
                      directed_rows[i].typed, directed_rows[i].want);
            sent_items++;
        end

        // Hold the result side off while header errors keep coming, so the
        // block backs up and drops in_ready.
        hold_asked++;
        repeat (30)
        begin
            push_byte(1'b1, 8'($urandom_range(0, 9)));
            sent_items++;
        end
        goal = sent_items + 90;
        while (sent_items < goal)
            send_frame(pick_kind(), 0);

        for (int ph = 0; ph < 7; ph++)
        begin
            wait_results_drained();
            repeat (8) @(posedge clk);
            max_frame_size_we <= 1'b1;
            max_frame_size    <= (ph == 6) ? 9'($urandom_range(11, 256)) : 9'(cfg_plan[ph]);
            @(posedge clk);
            max_frame_size_we <= 1'b0;
            chk_max_size = max_frame_size;
            if (ph == 6)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = idle_choice[$urandom_range(0, 2)];
                rx_idle_pct = idle_choice[$urandom_range(0, 2)];
            end
            goal = sent_items + phase_size[ph];
            if (cfg_plan[ph] == 511)
                send_frame(FRAME_GOOD, 255);
            while (sent_items < goal)
            begin
                send_frame(pick_kind(), 0);
                if (ph != 6 && $urandom_range(0, 24) == 0)
                    wait_results_drained();
            end
        end

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/rfcc_pkg.sv
hdl/radio_frame_crc_checker.sv
dv/tb_radio_frame_crc_checker.sv
